### design/csdcap_pkg.sv
// Package for the CSD capacity decode: item types, version codes and the
// version lookup functions. No dependencies.

package csdcap_pkg;

    localparam int unsigned CSD_W      = 128;
    localparam int unsigned COUNT_W    = 42;
    localparam int unsigned SPEC_W     = 9;
    localparam int unsigned SECBYTES_W = 16;

    // version codes, version times 100
    localparam logic [SPEC_W-1:0] SPEC_UNKNOWN = 9'd0;
    localparam logic [SPEC_W-1:0] SPEC_SD_100  = 9'd100;
    localparam logic [SPEC_W-1:0] SPEC_SD_200  = 9'd200;
    localparam logic [SPEC_W-1:0] SPEC_MMC_120 = 9'd120;
    localparam logic [SPEC_W-1:0] SPEC_MMC_122 = 9'd122;
    localparam logic [SPEC_W-1:0] SPEC_MMC_140 = 9'd140;
    localparam logic [SPEC_W-1:0] SPEC_MMC_300 = 9'd300;
    localparam logic [SPEC_W-1:0] SPEC_MMC_400 = 9'd400;
    localparam logic [SPEC_W-1:0] SPEC_MMC_410 = 9'd410;
    localparam logic [SPEC_W-1:0] SPEC_MMC_420 = 9'd420;
    localparam logic [SPEC_W-1:0] SPEC_MMC_430 = 9'd430;
    localparam logic [SPEC_W-1:0] SPEC_MMC_441 = 9'd441;
    localparam logic [SPEC_W-1:0] SPEC_MMC_450 = 9'd450;
    localparam logic [SPEC_W-1:0] SPEC_MMC_500 = 9'd500;
    localparam logic [SPEC_W-1:0] SPEC_MMC_510 = 9'd510;

    // CSD_STRUCTURE codes
    localparam logic [1:0] CSD_STRUCT_V1 = 2'd0;
    localparam logic [1:0] CSD_STRUCT_V2 = 2'd1;

    // READ_BL_LEN code for a 1024-byte sector
    localparam logic [3:0] BLLEN_1K = 4'd10;

    // MMC user area above this byte count comes from EXT_CSD
    localparam logic [40:0] MMC_BIG_BYTES = 41'h0_8000_0000;

    // SPEC_VERS codes of the MMC CSD
    localparam logic [3:0] MMC_VERS_1 = 4'd1;
    localparam logic [3:0] MMC_VERS_2 = 4'd2;
    localparam logic [3:0] MMC_VERS_3 = 4'd3;
    localparam logic [3:0] MMC_VERS_4 = 4'd4;

    // EXT_CSD_REV codes
    localparam logic [7:0] EXT_REV_0 = 8'd0;
    localparam logic [7:0] EXT_REV_1 = 8'd1;
    localparam logic [7:0] EXT_REV_2 = 8'd2;
    localparam logic [7:0] EXT_REV_3 = 8'd3;
    localparam logic [7:0] EXT_REV_5 = 8'd5;
    localparam logic [7:0] EXT_REV_6 = 8'd6;
    localparam logic [7:0] EXT_REV_7 = 8'd7;
    localparam logic [7:0] EXT_REV_8 = 8'd8;

    typedef struct packed {
        logic [7:0]  boot_size_mult;
        logic [31:0] ext_sector_count;
        logic [7:0]  ext_csd_rev;
        logic        is_mmc;
        logic [63:0] csd_high;
        logic [63:0] csd_low;
    } t_csd_in;

    typedef struct packed {
        logic [SPEC_W-1:0]     spec_code;
        logic [COUNT_W-1:0]    boot_sectors;
        logic [COUNT_W-1:0]    user_sectors;
        logic [SECBYTES_W-1:0] sector_bytes;
    } t_csd_out;

    function automatic logic [SPEC_W-1:0] mmc_base_version(input logic [3:0] code);
        logic [SPEC_W-1:0] v;
        case (code)
            MMC_VERS_1: v = SPEC_MMC_140;
            MMC_VERS_2: v = SPEC_MMC_122;
            MMC_VERS_3: v = SPEC_MMC_300;
            MMC_VERS_4: v = SPEC_MMC_400;
            default:    v = SPEC_MMC_120;
        endcase
        return v;
    endfunction

    function automatic logic [SPEC_W-1:0] mmc_ext_version(input logic [7:0] rev);
        logic [SPEC_W-1:0] v;
        case (rev)
            EXT_REV_0: v = SPEC_MMC_400;
            EXT_REV_1: v = SPEC_MMC_410;
            EXT_REV_2: v = SPEC_MMC_420;
            EXT_REV_3: v = SPEC_MMC_430;
            EXT_REV_5: v = SPEC_MMC_441;
            EXT_REV_6: v = SPEC_MMC_450;
            EXT_REV_7: v = SPEC_MMC_500;
            EXT_REV_8: v = SPEC_MMC_510;
            default:   v = SPEC_MMC_400;
        endcase
        return v;
    endfunction

endpackage

### design/csdcap_regslice.sv
// Register slice: one item register with valid flag and ready passed back.
// Depends on nothing; width set by parameter.

module csdcap_regslice #(
    parameter int unsigned W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic         r_valid;
    logic [W-1:0] r_data;

    // take a new item whenever the slot is empty or is being emptied
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### design/csdcap_decode.sv
// Combinational CSD decode: field extraction, capacity formulas, version code.
// Depends on csdcap_pkg.

module csdcap_decode
    import csdcap_pkg::*;
(
    input  t_csd_in  i_item,
    output t_csd_out o_result
);

    always_comb begin
        logic [CSD_W-1:0]   csd;
        logic [2:0]         mult;
        logic [11:0]        csize;
        logic [21:0]        c2;
        logic [3:0]         blshift;
        logic [1:0]         structure;
        logic [12:0]        csize_p1;
        logic [22:0]        c2_p1;
        logic [40:0]        mmc_bytes;
        logic [24:0]        boot_bytes;
        logic [COUNT_W-1:0] user;
        logic [COUNT_W-1:0] boot;
        logic [SPEC_W-1:0]  spec;
        logic               is_1k;

        csd       = {i_item.csd_high, i_item.csd_low};
        mult      = csd[49:47];
        csize     = csd[73:62];
        c2        = csd[69:48];
        blshift   = csd[83:80];
        structure = csd[127:126];
        csize_p1  = {1'b0, csize} + 13'd1;
        c2_p1     = {1'b0, c2} + 23'd1;
        mmc_bytes  = {i_item.ext_sector_count, 9'b0};
        boot_bytes = {i_item.boot_size_mult, 17'b0};

        user = COUNT_W'(csize_p1) << ({1'b0, mult} + 4'd2);
        boot = '0;
        spec = SPEC_UNKNOWN;

        if (i_item.is_mmc) begin
            spec = mmc_base_version(csd[125:122]);
            if (structure[1] && spec == SPEC_MMC_400) begin
                spec = mmc_ext_version(i_item.ext_csd_rev);
            end
            if (spec >= SPEC_MMC_420) begin
                if (mmc_bytes > MMC_BIG_BYTES) begin
                    user = COUNT_W'(mmc_bytes >> blshift);
                end
                boot = COUNT_W'(boot_bytes >> blshift);
            end
        end else begin
            if (structure == CSD_STRUCT_V1) begin
                spec = SPEC_SD_100;
            end else if (structure == CSD_STRUCT_V2) begin
                spec = SPEC_SD_200;
                user = {c2_p1, 19'b0} >> blshift;
            end
        end

        // report a 1 KiB sector as two 512-byte sectors
        is_1k = (blshift == BLLEN_1K);
        o_result.sector_bytes = is_1k ? 16'd512 : (16'd1 << blshift);
        o_result.user_sectors = is_1k ? {user[COUNT_W-2:0], 1'b0} : user;
        o_result.boot_sectors = is_1k ? {boot[COUNT_W-2:0], 1'b0} : boot;
        o_result.spec_code    = spec;
    end

endmodule

### design/sd_mmc_csd_capacity_decode_core.sv
// Top level of the SD/MMC CSD capacity decode: input slice, decode, output slice.
// Depends on csdcap_pkg, csdcap_regslice and csdcap_decode.
//
//  channel   dir  signals                          payload
//  s (item)  in   i_s_tvalid o_s_tready            i_s_tdata 176b, i_s_tuser 1b
//  m (result) out o_m_tvalid i_m_tready            o_m_tdata 112b
//
// One item per cycle sustained while the result side is ready; an item passes through
// the input register, the decode logic and then the result register.
// Reset (synchronous, active low) empties both registers.
// A stall on the result side holds the result register and backs up through the
// input register; with both full the input side is not ready.

module sd_mmc_csd_capacity_decode_core
    import csdcap_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // csd_low[63:0], csd_high[127:64], ext_csd_rev[135:128],
    // ext_sector_count[167:136], boot_size_mult[175:168]
    input  logic [175:0] i_s_tdata,
    // is_mmc[0]
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // sector_bytes[15:0], user_sectors[57:16], boot_sectors[99:58],
    // spec_code[108:100], zero[111:109]
    output logic [111:0] o_m_tdata
);

    localparam int unsigned IN_W  = $bits(t_csd_in);
    localparam int unsigned OUT_W = $bits(t_csd_out);

    t_csd_in  in_item;
    t_csd_in  dec_item;
    t_csd_out dec_result;
    t_csd_out out_result;
    logic     dec_valid;
    logic     dec_ready;

    always_comb begin
        in_item.csd_low          = i_s_tdata[63:0];
        in_item.csd_high         = i_s_tdata[127:64];
        in_item.ext_csd_rev      = i_s_tdata[135:128];
        in_item.ext_sector_count = i_s_tdata[167:136];
        in_item.boot_size_mult   = i_s_tdata[175:168];
        in_item.is_mmc           = i_s_tuser;
    end

    csdcap_regslice #(.W(IN_W)) u_in_slice (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (in_item),
        .o_valid (dec_valid),
        .i_ready (dec_ready),
        .o_data  (dec_item)
    );

    csdcap_decode u_decode (
        .i_item   (dec_item),
        .o_result (dec_result)
    );

    csdcap_regslice #(.W(OUT_W)) u_out_slice (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_data  (dec_result),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_result)
    );

    assign o_m_tdata = {3'b000, out_result.spec_code, out_result.boot_sectors,
                        out_result.user_sectors, out_result.sector_bytes};

    // sector size is always a single power of two, never 1 KiB
    a_secbytes_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($onehot(o_m_tdata[15:0]) && o_m_tdata[15:0] != 16'd1024))
        else $error("sector size not a valid power of two");

    // boot partitions only reported for MMC 4.2 and later
    a_boot_needs_420: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[99:58] != 42'd0) |-> (o_m_tdata[108:100] >= SPEC_MMC_420))
        else $error("boot sectors reported below MMC 4.2");

    // an item taken into an empty pipe passes the input register and reaches the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !dec_valid && !o_m_tvalid) |=> ##1 o_m_tvalid)
        else $error("item lost between input and result register");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[111:109] == 3'b000))
        else $error("result padding not zero");

endmodule

### tb/tb_sd_mmc_csd_capacity_decode_core.sv
// Self-checking bench for sd_mmc_csd_capacity_decode_core: directed and random CSD
// images with random idling on both stream sides. Depends on csdcap_pkg and sd_mmc_csd_capacity_decode_core.
`timescale 1ns / 100ps

module tb_sd_mmc_csd_capacity_decode_core;
    import csdcap_pkg::*;

    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned DRAIN_CYCLES = 10;

    // structure codes and revisions that the package leaves unnamed
    localparam logic [1:0] CSD_STRUCT_RSVD2 = 2'd2;
    localparam logic [1:0] CSD_STRUCT_RSVD3 = 2'd3;
    localparam logic [3:0] MMC_VERS_RSVD = 4'd9;
    localparam logic [7:0] EXT_REV_4 = 8'd4;
    localparam logic [7:0] EXT_REV_MAX = 8'hFF;
    localparam logic [31:0] EXT_COUNT_2G = 32'h0040_0000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [175:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         o_m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] o_m_tdata;

    t_csd_in  csd_items[$];
    t_csd_out exp_results[$];
    t_csd_in  cur_item = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned phase_no = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned n_items = 0;
    int unsigned n_directed = 0;
    int unsigned n_sd2 = 0;
    int unsigned n_mmc_ext = 0;
    int unsigned n_checked = 0;
    int unsigned n_fail = 0;

    sd_mmc_csd_capacity_decode_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_csd_out decode_capacity(input t_csd_in it);
        logic [127:0]      csd;
        logic [3:0]        bl;
        logic [1:0]        st;
        logic [63:0]       secb;
        logic [63:0]       user;
        logic [63:0]       boot;
        logic [63:0]       bytes;
        int unsigned       shamt;
        logic [SPEC_W-1:0] spec;
        t_csd_out          r;
        csd = {it.csd_high, it.csd_low};
        bl = csd[83:80];
        st = csd[127:126];
        secb = 64'd1 << bl;
        shamt = csd[49:47] + 2;
        user = ({52'd0, csd[73:62]} + 64'd1) << shamt;
        boot = '0;
        spec = SPEC_UNKNOWN;
        if (it.is_mmc) begin
            case (csd[125:122])
                MMC_VERS_1: spec = SPEC_MMC_140;
                MMC_VERS_2: spec = SPEC_MMC_122;
                MMC_VERS_3: spec = SPEC_MMC_300;
                MMC_VERS_4: spec = SPEC_MMC_400;
                default:    spec = SPEC_MMC_120;
            endcase
            // refine by EXT_CSD revision only for structure 2 or 3
            if (st[1] && spec == SPEC_MMC_400) begin
                case (it.ext_csd_rev)
                    EXT_REV_1: spec = SPEC_MMC_410;
                    EXT_REV_2: spec = SPEC_MMC_420;
                    EXT_REV_3: spec = SPEC_MMC_430;
                    EXT_REV_5: spec = SPEC_MMC_441;
                    EXT_REV_6: spec = SPEC_MMC_450;
                    EXT_REV_7: spec = SPEC_MMC_500;
                    EXT_REV_8: spec = SPEC_MMC_510;
                    default:   spec = SPEC_MMC_400;
                endcase
            end
            if (spec >= SPEC_MMC_420) begin
                bytes = {32'd0, it.ext_sector_count} << 9;
                if (bytes > MMC_BIG_BYTES)
                    user = bytes >> bl;
                // boot size is in 128 KiB units
                boot = ({56'd0, it.boot_size_mult} << 17) >> bl;
            end
        end else if (st == CSD_STRUCT_V1) begin
            spec = SPEC_SD_100;
        end else if (st == CSD_STRUCT_V2) begin
            spec = SPEC_SD_200;
            user = (({42'd0, csd[69:48]} + 64'd1) << 19) >> bl;
        end
        if (bl == BLLEN_1K) begin
            secb = 64'd512;
            user = user << 1;
            boot = boot << 1;
        end
        r.sector_bytes = secb[SECBYTES_W-1:0];
        r.user_sectors = user[COUNT_W-1:0];
        r.boot_sectors = boot[COUNT_W-1:0];
        r.spec_code = spec;
        return r;
    endfunction

    function automatic logic [127:0] csd_image(input logic [1:0] st, input logic [3:0] vers,
                                               input logic [3:0] bl, input logic [11:0] csize,
                                               input logic [2:0] mult);
        logic [127:0] c;
        c = '0;
        c[127:126] = st;
        c[125:122] = vers;
        c[83:80] = bl;
        c[73:62] = csize;
        c[49:47] = mult;
        return c;
    endfunction

    task automatic queue_item(input logic [127:0] csd, input logic mmc, input logic [7:0] rev,
                              input logic [31:0] cnt, input logic [7:0] bmult);
        t_csd_in it;
        it.csd_low = csd[63:0];
        it.csd_high = csd[127:64];
        it.is_mmc = mmc;
        it.ext_csd_rev = rev;
        it.ext_sector_count = cnt;
        it.boot_size_mult = bmult;
        csd_items.push_back(it);
    endtask

    // mostly well-formed SD v1/v2 and MMC 4.x images over a random background
    task automatic queue_random_item();
        logic [127:0] c;
        logic         mmc;
        logic [7:0]   rev;
        logic [31:0]  cnt;
        c = {$urandom, $urandom, $urandom, $urandom};
        mmc = 1'($urandom_range(0, 1));
        rev = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
        if (mmc && $urandom_range(0, 9) < 7) begin
            c[127] = 1'b1;
            c[125:122] = MMC_VERS_4;
        end else if (!mmc && $urandom_range(0, 9) < 8) begin
            c[127:126] = 2'($urandom_range(0, 1));
        end
        case ($urandom_range(0, 3))
            0:       c[83:80] = 4'd9;
            1:       c[83:80] = BLLEN_1K;
            2:       c[83:80] = 4'd11;
            default: c[83:80] = 4'($urandom);
        endcase
        case ($urandom_range(0, 2))
            0:       cnt = $urandom;
            1:       cnt = EXT_COUNT_2G - 32'd2 + 32'($urandom_range(0, 4));
            default: cnt = $urandom_range(0, EXT_COUNT_2G);
        endcase
        queue_item(c, mmc, rev, cnt, 8'($urandom));
    endtask

    // driver: hold the item until taken, then advance or idle
    always @(posedge i_clk) begin
        t_csd_out r;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                r = decode_capacity(cur_item);
                exp_results.push_back(r);
                n_items++;
                if (r.spec_code == SPEC_SD_200)
                    n_sd2++;
                if (r.spec_code >= SPEC_MMC_420)
                    n_mmc_ext++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (csd_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_item = csd_items.pop_front();
                    s_tdata <= {cur_item.boot_size_mult, cur_item.ext_sector_count,
                                cur_item.ext_csd_rev, cur_item.csd_high, cur_item.csd_low};
                    s_tuser <= cur_item.is_mmc;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_csd_out got;
        t_csd_out want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                got = t_csd_out'(o_m_tdata[108:0]);
                n_checked++;
                if (exp_results.size() == 0) begin
                    $error("unexpected result item %h", o_m_tdata);
                    n_fail++;
                end else begin
                    want = exp_results.pop_front();
                    if (got.sector_bytes !== want.sector_bytes) begin
                        $error("sector_bytes: expected %0d, got %0d",
                               want.sector_bytes, got.sector_bytes);
                        n_fail++;
                    end
                    if (got.user_sectors !== want.user_sectors) begin
                        $error("user_sectors: expected %0d, got %0d",
                               want.user_sectors, got.user_sectors);
                        n_fail++;
                    end
                    if (got.boot_sectors !== want.boot_sectors) begin
                        $error("boot_sectors: expected %0d, got %0d",
                               want.boot_sectors, got.boot_sectors);
                        n_fail++;
                    end
                    if (got.spec_code !== want.spec_code) begin
                        $error("spec_code: expected %0d, got %0d",
                               want.spec_code, got.spec_code);
                        n_fail++;
                    end
                end
            end
            // one long hold-off early in the last phase so both slices fill
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (phase_no == 2 && !hold_done && o_m_tvalid) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        logic [127:0] c;
        logic [7:0]   rev_list [10];
        logic [31:0]  cnt_list [4];
        logic [3:0]   bl_list [4];
        logic [3:0]   vers_list [4];
        rev_list = '{EXT_REV_0, EXT_REV_1, EXT_REV_2, EXT_REV_3, EXT_REV_4,
                     EXT_REV_5, EXT_REV_6, EXT_REV_7, EXT_REV_8, EXT_REV_MAX};
        cnt_list = '{32'd0, EXT_COUNT_2G, EXT_COUNT_2G + 32'd1, 32'hFFFF_FFFF};
        bl_list = '{4'd9, BLLEN_1K, 4'd15, 4'd0};
        vers_list = '{MMC_VERS_1, MMC_VERS_2, MMC_VERS_3, MMC_VERS_RSVD};

        send_idle_pct = 29;
        recv_idle_pct = 47;

        // directed: field extremes, every SD formula and every MMC version path
        queue_item('0, 1'b0, 8'd0, 32'd0, 8'd0);
        queue_item('1, 1'b0, EXT_REV_MAX, 32'hFFFF_FFFF, 8'hFF);
        queue_item('1, 1'b1, EXT_REV_MAX, 32'hFFFF_FFFF, 8'hFF);
        queue_item(csd_image(CSD_STRUCT_V1, 4'd0, 4'd9, 12'hFFF, 3'd7), 1'b0, 8'd0, 32'd0, 8'd0);
        queue_item(csd_image(CSD_STRUCT_V1, 4'd0, BLLEN_1K, 12'h123, 3'd3),
                   1'b0, 8'd0, 32'd0, 8'd0);
        c = csd_image(CSD_STRUCT_V2, 4'd0, 4'd0, 12'd0, 3'd0);
        c[69:48] = '1;
        queue_item(c, 1'b0, 8'd0, 32'd0, 8'd0);
        queue_item(csd_image(CSD_STRUCT_V2, 4'd0, 4'd15, 12'd0, 3'd0), 1'b0, 8'd0, 32'd0, 8'd0);
        c = csd_image(CSD_STRUCT_V2, 4'd0, BLLEN_1K, 12'd0, 3'd0);
        c[69:48] = 22'h1234;
        queue_item(c, 1'b0, 8'd0, 32'd0, 8'd0);
        queue_item(csd_image(CSD_STRUCT_RSVD2, 4'd0, 4'd9, 12'h0AB, 3'd2),
                   1'b0, 8'd0, 32'd0, 8'd0);
        for (int i = 0; i < 4; i++)
            queue_item(csd_image(CSD_STRUCT_V2, vers_list[i], 4'd9, 12'h7FF, 3'(i)),
                       1'b1, EXT_REV_2, 32'hFFFF_FFFF, 8'hFF);
        // version 4 with structure 1: no refinement, EXT_CSD ignored
        queue_item(csd_image(CSD_STRUCT_V2, MMC_VERS_4, 4'd9, 12'h100, 3'd4),
                   1'b1, EXT_REV_8, 32'hFFFF_FFFF, 8'hFF);
        for (int i = 0; i < 10; i++)
            queue_item(csd_image((i % 2) ? CSD_STRUCT_RSVD3 : CSD_STRUCT_RSVD2, MMC_VERS_4,
                                 bl_list[i % 4], 12'($urandom), 3'($urandom)),
                       1'b1, rev_list[i], cnt_list[i % 4],
                       (i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'hFF : 8'($urandom));
        n_directed = csd_items.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 3; p++) begin
            for (int i = 0; i < 316; i++)
                queue_random_item();
            while (csd_items.size() != 0 || s_tvalid)
                @(negedge i_clk);
            if (p == 0) begin
                send_idle_pct = 47;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            phase_no = p + 1;
        end

        while (exp_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Decoded %0d items (%0d directed), %0d results checked;", n_items, n_directed,
                 n_checked);
        $display("%0d took the SD 2.0 formula and %0d the MMC 4.2+ EXT_CSD path.", n_sd2,
                 n_mmc_ext);
        if (n_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sd_mmc_csd_capacity_decode_core.f
design/csdcap_pkg.sv
design/csdcap_regslice.sv
design/csdcap_decode.sv
design/sd_mmc_csd_capacity_decode_core.sv
tb/tb_sd_mmc_csd_capacity_decode_core.sv
